FILE: rtl/fcsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsc_pkg
// Shared types and constants of the finger curvature shape classifier.
// ----------------------------------------------------------------------------
package fcsc_pkg;
  localparam int FINGERS = 3;
  localparam int CURV_W = 16;
  localparam int THR_W = 15;
  localparam int RADIUS_W = 32;
  localparam int CONF_W = 9;

  localparam logic [1:0] CLS_UNKNOWN = 2'd0;
  localparam logic [1:0] CLS_PLANE = 2'd1;
  localparam logic [1:0] CLS_SPHERE = 2'd2;
  localparam logic [1:0] CLS_CYLINDER = 2'd3;

  localparam logic [CONF_W-1:0] CONF_FULL = 9'd256;
  localparam logic [CONF_W-1:0] CONF_CYL = 9'd154;
  localparam logic [CONF_W-1:0] CONF_OTHER = 9'd77;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = 32'h7fff_ffff;

  localparam logic [0:0] REG_FLAT = 1'b0;
  localparam logic [0:0] REG_UNIFORM = 1'b1;

  // per-finger lane result
  typedef struct packed {
    logic        valid;
    logic [15:0] mag;
    logic [31:0] sq;
  } lane_t;
endpackage
`default_nettype wire

FILE: rtl/fcsc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsc_in_if / fcsc_out_if
// Valid/ready channels carrying classifier items and results.
// ----------------------------------------------------------------------------
interface fcsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] curvature_thumb;
  logic signed [15:0] curvature_index;
  logic signed [15:0] curvature_middle;
  logic [2:0]         curvature_valid_mask;
  logic [15:0]        reading_valid_mask;
  modport source (output valid, curvature_thumb, curvature_index, curvature_middle,
                  curvature_valid_mask, reading_valid_mask, input ready);
  modport sink (input valid, curvature_thumb, curvature_index, curvature_middle,
                curvature_valid_mask, reading_valid_mask, output ready);
endinterface

interface fcsc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         shape_class;
  logic [8:0]         confidence;
  logic signed [31:0] radius;
  logic [4:0]         points_used;
  modport source (output valid, shape_class, confidence, radius, points_used,
                  input ready);
  modport sink (input valid, shape_class, confidence, radius, points_used,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/fcsc_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsc_lane
// One finger lane: magnitude and square of a curvature.
// ----------------------------------------------------------------------------
module fcsc_lane
  import fcsc_pkg::*;
(
  input  wire logic signed [15:0] curv,
  input  wire logic               en,
  output lane_t                   lane
);
  logic [16:0] mag;
  assign mag = curv[15] ? 17'(-{curv[15], curv}) : 17'({1'b0, curv});
  assign lane.valid = en;
  // magnitude of -32768 is 32768: keep 16 bits plus square on full value
  assign lane.mag = mag[15:0];
  assign lane.sq = 32'(mag * mag);
endmodule
`default_nettype wire

FILE: rtl/fcsc_divu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsc_divu
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fcsc_divu #(
  parameter int NW = 32,
  parameter int DW = 20,
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [TW-1:0] tag_in,
  output logic [NW-1:0]      quo,
  output logic [TW-1:0]      tag_out
);
  logic [NW-1:0] q_r [NW+1];
  logic [DW:0]   r_r [NW+1];
  logic [DW-1:0] d_r [NW+1];
  logic [TW-1:0] t_r [NW+1];

  always_comb begin
    q_r[0] = num;
    r_r[0] = '0;
    d_r[0] = den;
    t_r[0] = tag_in;
  end

  for (genvar g = 0; g < NW; g++) begin : g_st
    logic [DW+1:0] rem_sh;
    logic [DW+1:0] diff;
    logic [NW-1:0] q_next;
    assign rem_sh = {r_r[g], q_r[g][NW-1-g]};
    assign diff = rem_sh - {2'b0, d_r[g]};
    // the consumed dividend bit becomes the quotient bit
    always_comb begin
      q_next = q_r[g];
      q_next[NW-1-g] = !diff[DW+1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[g+1] <= q_next;
        d_r[g+1] <= d_r[g];
        t_r[g+1] <= t_r[g];
        r_r[g+1] <= diff[DW+1] ? rem_sh[DW:0] : diff[DW:0];
      end
    end
  end
  assign quo = q_r[NW];
  assign tag_out = t_r[NW];
endmodule
`default_nettype wire

FILE: rtl/fcsc_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsc_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module fcsc_isqrt #(
  parameter int HW = 26,
  parameter int TW = 8
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [2*HW-1:0] val,
  input  wire logic [TW-1:0]   tag_in,
  output logic [HW-1:0]        root,
  output logic [TW-1:0]        tag_out
);
  logic [2*HW-1:0] v_r [HW+1];
  logic [HW+1:0]   rm_r [HW+1];
  logic [HW-1:0]   rt_r [HW+1];
  logic [TW-1:0]   t_r [HW+1];

  always_comb begin
    v_r[0] = val;
    rm_r[0] = '0;
    rt_r[0] = '0;
    t_r[0] = tag_in;
  end

  for (genvar g = 0; g < HW; g++) begin : g_st
    logic [HW+3:0] rs;
    logic [HW+3:0] trial;
    logic [HW+3:0] diff;
    assign rs = {rm_r[g], v_r[g][2*HW-1-2*g -: 2]};
    assign trial = {2'b0, rt_r[g], 2'b01};
    assign diff = rs - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[g+1] <= v_r[g];
        t_r[g+1] <= t_r[g];
        if (!diff[HW+3]) begin
          rm_r[g+1] <= diff[HW+1:0];
          rt_r[g+1] <= {rt_r[g][HW-2:0], 1'b1};
        end else begin
          rm_r[g+1] <= rs[HW+1:0];
          rt_r[g+1] <= {rt_r[g][HW-2:0], 1'b0};
        end
      end
    end
  end
  assign root = rt_r[HW];
  assign tag_out = t_r[HW];
endmodule
`default_nettype wire

FILE: rtl/finger_curvature_shape_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// finger_curvature_shape_classifier
// Classifies a touched object from three finger curvatures.
// ----------------------------------------------------------------------------
// Usage:
//   in  : valid/ready channel, one item holds three Q5.10 curvatures, their
//         valid mask and the distance reading mask.
//   out : valid/ready channel, one result per item: class, confidence,
//         Q15.16 radius and count of valid readings.
//   cfg : APB write/read of flat_threshold (0x0) and uniform_threshold (0x4).
// Throughput is one item per cycle while the output is not stalled. Three
// stages of lane statistics, merge and decision inputs come first, then a
// 26-stage square root feeding a 32-stage divider for the sphere confidence,
// while the plane and radius dividers (32 stages) run alongside with 26 delay
// stages, then the output register.
// The whole pipeline advances only when the output register is free or
// taken, so a stalled receiver holds every stage and deasserts in.ready.
// Reset clears all valid bits and loads the threshold reset values.
// ----------------------------------------------------------------------------
module finger_curvature_shape_classifier
  import fcsc_pkg::*;
#(
  parameter int SENSOR_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  fcsc_in_if.sink          in_ch,
  fcsc_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int SW = (SENSOR_COUNT < 16) ? SENSOR_COUNT : 16;
  localparam int PL = 58;

  logic [THR_W-1:0] flat, uni;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      flat <= 15'd1024;
      uni <= 15'd2048;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_FLAT: flat <= pwdata[THR_W-1:0];
        REG_UNIFORM: uni <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end
  assign prdata = paddr[2] == REG_UNIFORM ? {17'd0, uni} : {17'd0, flat};

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: lanes
  lane_t lanes [FINGERS];
  logic signed [15:0] kin [FINGERS];
  assign kin[0] = in_ch.curvature_thumb;
  assign kin[1] = in_ch.curvature_index;
  assign kin[2] = in_ch.curvature_middle;
  for (genvar f = 0; f < FINGERS; f++) begin : g_lane
    fcsc_lane u_lane (.curv(kin[f]), .en(in_ch.curvature_valid_mask[f]), .lane(lanes[f]));
  end

  logic v1;
  lane_t l1 [FINGERS];
  logic signed [15:0] k1 [FINGERS];
  logic [4:0] pts1;
  logic [4:0] pc;
  always_comb begin
    pc = '0;
    for (int i = 0; i < SW; i++) pc = pc + 5'(in_ch.reading_valid_mask[i]);
  end
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_ch.valid;
    if (adv) begin
      l1 <= lanes;
      k1 <= kin;
      pts1 <= pc;
    end
  end

  // stage 2: merge
  logic [1:0] n_c;
  logic signed [17:0] s_c;
  logic [33:0] q_c;
  logic [16:0] m_c;
  always_comb begin
    n_c = '0; s_c = '0; q_c = '0; m_c = '0;
    for (int i = 0; i < FINGERS; i++) begin
      if (l1[i].valid) begin
        n_c = n_c + 2'd1;
        s_c = s_c + 18'(k1[i]);
        q_c = q_c + 34'(l1[i].sq);
        if (17'(l1[i].mag) > m_c)
          m_c = 17'(l1[i].mag);
      end
    end
  end

  logic v2;
  logic [1:0] n2;
  logic signed [17:0] s2;
  logic [33:0] q2;
  logic [16:0] m2;
  logic signed [15:0] ki2, km2;
  logic im2;
  logic [4:0] pts2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      n2 <= n_c; s2 <= s_c; q2 <= q_c; m2 <= m_c;
      ki2 <= k1[1]; km2 <= k1[2];
      im2 <= l1[1].valid && l1[2].valid;
      pts2 <= pts1;
    end
  end

  // stage 3: D, limits, decision inputs
  logic [35:0] nq;
  logic [35:0] ss;
  logic signed [36:0] d_s;
  logic [35:0] d_c;
  logic [16:0] lim_c;
  logic [33:0] lim2_c;
  logic [16:0] s_abs;
  logic [33:0] ss_tmp;
  assign nq = 36'(q2) * 36'(n2);
  assign s_abs = s2[17] ? 17'(-s2) : 17'(s2);
  assign ss_tmp = {17'd0, s_abs} * {17'd0, s_abs};
  assign ss = 36'(ss_tmp);
  assign d_s = $signed({1'b0, nq}) - $signed({1'b0, ss});
  assign d_c = d_s[36] ? '0 : d_s[35:0];
  assign lim_c = 17'(uni) * 17'(n2);

  logic v3;
  logic [1:0] n3;
  logic signed [17:0] s3;
  logic [35:0] d3;
  logic [16:0] lim3, m3;
  logic signed [15:0] ki3, km3;
  logic im3;
  logic [4:0] pts3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      n3 <= n2; s3 <= s2; d3 <= d_c; lim3 <= lim_c; m3 <= m2;
      ki3 <= ki2; km3 <= km2; im3 <= im2; pts3 <= pts2;
    end
  end
  assign lim2_c = 34'(lim3) * 34'(lim3);

  // classification tag, computed once at stage 4 entry
  logic [1:0] cls_c;
  logic signed [16:0] sum_c, dif_c;
  logic [16:0] adif, aki, asum;
  logic sneg;
  assign sum_c = 17'(ki3) + 17'(km3);
  assign dif_c = 17'(ki3) - 17'(km3);
  assign adif = dif_c[16] ? 17'(-dif_c) : 17'(dif_c);
  assign aki = ki3[15] ? 17'(-17'(ki3)) : 17'(ki3);
  assign asum = sum_c[16] ? 17'(-sum_c) : 17'(sum_c);
  assign sneg = sum_c[16];
  always_comb begin
    if (n3 < 2'd2) cls_c = CLS_UNKNOWN;
    else if (m3 < 17'(flat)) cls_c = CLS_PLANE;
    else if (!s3[17] && s3 != '0 && 36'(lim2_c) > d3) cls_c = CLS_SPHERE;
    else if (im3 && adif < 17'(uni) && aki > 17'(flat)) cls_c = CLS_CYLINDER;
    else cls_c = CLS_UNKNOWN;
  end

  // valid bits travel in their own reset chain beside the long paths
  logic [PL-1:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (adv) vpipe <= {vpipe[PL-2:0], v3};
  end

  // tag: n>=2, cls, sneg, sum zero, pts, lim(17), flat(15)
  localparam int TW = 1 + 2 + 1 + 1 + 5 + 17 + 15;
  logic [TW-1:0] tag_c, tag_a, tag_b, tag_c2, tag_d;
  assign tag_c = {n3 >= 2'd2, cls_c, sneg, sum_c == '0, pts3, lim3, flat};

  // sphere confidence: sqrt(D*65536), then divided by lim
  logic [25:0] root;
  logic [51:0] sq_in;
  assign sq_in = {d3[35:0], 16'd0};
  fcsc_isqrt #(.HW(26), .TW(TW)) u_sqrt (
    .clk(clk), .en(adv), .val(sq_in), .tag_in(tag_c), .root(root), .tag_out(tag_a));

  logic [31:0] sdiv_q;
  fcsc_divu #(.NW(32), .DW(17), .TW(TW)) u_cdiv (
    .clk(clk), .en(adv), .num({6'd0, root}), .den(tag_a[31:15]), .tag_in(tag_a),
    .quo(sdiv_q), .tag_out(tag_b));

  // plane confidence: 256*M / flat, delayed to match
  logic [31:0] pl_q;
  logic [TW-1:0] tag_p;
  logic [31:0] pl_num;
  assign pl_num = {7'd0, m3, 8'd0};
  fcsc_divu #(.NW(32), .DW(15), .TW(TW)) u_pdiv (
    .clk(clk), .en(adv), .num(pl_num), .den(flat), .tag_in(tag_c),
    .quo(pl_q), .tag_out(tag_p));

  // radius: sphere (n*2^26 + s/2)/s, cylinder (2^27 + |sum|/2)/|sum|
  logic [31:0] rnum;
  logic [16:0] rden;
  always_comb begin
    if (cls_c == CLS_SPHERE) begin
      rnum = 32'(n3) * 32'h0400_0000 + 32'(s3[17:1]);
      rden = s3[16:0];
    end else begin
      rnum = 32'h0800_0000 + 32'(asum[16:1]);
      rden = (asum == '0) ? 17'd1 : asum;
    end
  end
  logic [31:0] r_q;
  logic [TW-1:0] tag_r;
  fcsc_divu #(.NW(32), .DW(17), .TW(TW)) u_rdiv (
    .clk(clk), .en(adv), .num(rnum), .den(rden), .tag_in(tag_c),
    .quo(r_q), .tag_out(tag_r));

  // align sphere confidence (26+32 stages) with the 32-stage paths
  logic [31:0] plq_d [26];
  logic [31:0] rq_d [26];
  logic [TW-1:0] tr_d [26];
  always_ff @(posedge clk) begin
    if (adv) begin
      plq_d[0] <= pl_q; rq_d[0] <= r_q; tr_d[0] <= tag_r;
      for (int i = 1; i < 26; i++) begin
        plq_d[i] <= plq_d[i-1]; rq_d[i] <= rq_d[i-1]; tr_d[i] <= tr_d[i-1];
      end
    end
  end
  assign tag_d = tr_d[25];
  assign tag_c2 = tag_p;

  // final select
  logic [TW-1:0] tf;
  assign tf = tag_d;
  logic vf, okf, snf, zf;
  logic [1:0] clf;
  logic [4:0] ptf;
  assign vf = vpipe[PL-1];
  assign okf = tf[TW-1];
  assign clf = tf[TW-2 -: 2];
  assign snf = tf[TW-4];
  assign zf = tf[TW-5];
  assign ptf = tf[TW-6 -: 5];

  logic [8:0] conf_c;
  logic [31:0] rad_c;
  always_comb begin
    conf_c = '0;
    rad_c = '0;
    if (okf) begin
      case (clf)
        CLS_PLANE: conf_c = 9'(CONF_FULL - 9'(plq_d[25]));
        CLS_SPHERE: begin
          conf_c = 9'(CONF_FULL - 9'(sdiv_q));
          rad_c = rq_d[25][31] ? RADIUS_MAX : rq_d[25];
        end
        CLS_CYLINDER: begin
          conf_c = CONF_CYL;
          if (zf) rad_c = RADIUS_MAX;
          else rad_c = snf ? 32'(-rq_d[25]) : rq_d[25];
        end
        default: conf_c = CONF_OTHER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (adv) out_ch.valid <= vf;
    if (adv) begin
      out_ch.shape_class <= okf ? clf : CLS_UNKNOWN;
      out_ch.confidence <= conf_c;
      out_ch.radius <= rad_c;
      out_ch.points_used <= okf ? ptf : 5'd0;
    end
  end

`ifndef ASSERT_OFF
  a_tag_align: assert property (@(posedge clk) disable iff (rst)
    tag_b === tag_d) else $error("sqrt path tag misaligned");
  a_plane_tag: assert property (@(posedge clk) disable iff (rst)
    tag_c2 === tag_r) else $error("plane path misaligned");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_pts: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.points_used <= 5'd16) else $error("points out of range");
`endif
endmodule
`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the finger curvature shape classifier: drives
// curvature items with bursty flow, stalls the result side, predicts each
// result from the same integer arithmetic and compares field by field.
// ----------------------------------------------------------------------------
module tb;
  import fcsc_pkg::*;

  typedef struct packed {
    logic [1:0]         cls;
    logic [8:0]         conf;
    logic signed [31:0] radius;
    logic [4:0]         pts;
  } shape_t;

  localparam int LATENCY = 62;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fcsc_in_if in_ch();
  fcsc_out_if out_ch();

  finger_curvature_shape_classifier u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [14:0] flat_thr, uni_thr;
  shape_t expected_shapes[$];
  int mismatches = 0;
  bit hold_off = 1'b0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint absl(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic shape_t classify(logic signed [15:0] kt, logic signed [15:0] ki,
                                      logic signed [15:0] km, logic [2:0] vm,
                                      logic [15:0] rm);
    shape_t r;
    longint k[3];
    longint n, s, q, m, d, lim, num, sum, as, mag, rad, flat, uni;
    longint unsigned s8;
    r = '0;
    k[0] = kt; k[1] = ki; k[2] = km;
    n = 0; s = 0; q = 0; m = 0; rad = 0;
    flat = flat_thr;
    uni = uni_thr;
    for (int i = 0; i < 3; i++) begin
      if (vm[i]) begin
        n++;
        s += k[i];
        q += k[i] * k[i];
        if (absl(k[i]) > m) m = absl(k[i]);
      end
    end
    if (n >= 2) begin
      r.pts = 5'($countones(rm));
      d = n * q - s * s;
      if (d < 0) d = 0;
      lim = n * uni;
      if (m < flat) begin
        r.cls = CLS_PLANE;
        r.conf = 9'(256 - (m * 256) / flat);
      end else if (s > 0 && d < lim * lim) begin
        s8 = isqrt(longint'(d) * 65536);
        num = n * (64'sd1 << 26);
        r.cls = CLS_SPHERE;
        r.conf = 9'(256 - s8 / longint'(lim));
        rad = (num + s / 2) / s;
        if (rad > 64'sd2147483647) rad = 64'sd2147483647;
      end else if (vm[2:1] == 2'b11 && absl(k[1] - k[2]) < uni && absl(k[1]) > flat) begin
        sum = k[1] + k[2];
        r.cls = CLS_CYLINDER;
        r.conf = CONF_CYL;
        if (sum == 0) begin
          rad = 64'sd2147483647;
        end else begin
          as = absl(sum);
          mag = ((64'sd1 << 27) + as / 2) / as;
          rad = sum < 0 ? -mag : mag;
        end
      end else begin
        r.cls = CLS_UNKNOWN;
        r.conf = CONF_OTHER;
      end
    end
    r.radius = rad[31:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // bursty sender: a new burst is usually preceded by a gap of random length
  int burst_left = 0;
  task automatic send_item(logic signed [15:0] kt, logic signed [15:0] ki,
                           logic signed [15:0] km, logic [2:0] vm, logic [15:0] rm);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.curvature_thumb <= kt;
    in_ch.curvature_index <= ki;
    in_ch.curvature_middle <= km;
    in_ch.curvature_valid_mask <= vm;
    in_ch.reading_valid_mask <= rm;
    do @(posedge clk); while (!in_ch.ready);
    expected_shapes.push_back(classify(kt, ki, km, vm, rm));
  endtask

  task automatic idle_sender();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stall pattern; a long hold-off overrides it
  int stall_mode = 0;
  always @(posedge clk) begin
    if (rst || hold_off) out_ch.ready <= 1'b0;
    else case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      shape_t w;
      if (expected_shapes.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        w = expected_shapes.pop_front();
        if (out_ch.shape_class !== w.cls) report("shape_class", out_ch.shape_class, w.cls);
        if (out_ch.confidence !== w.conf) report("confidence", out_ch.confidence, w.conf);
        if (out_ch.radius !== w.radius) report("radius", out_ch.radius, w.radius);
        if (out_ch.points_used !== w.pts) report("points_used", out_ch.points_used, w.pts);
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_FLAT) flat_thr = val[14:0];
    else uni_thr = val[14:0];
    @(posedge clk);
  endtask

  task automatic drain();
    idle_sender();
    while (expected_shapes.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic test_directed();
    logic signed [15:0] lo = 16'sh8000, hi = 16'sh7fff;
    send_item(0, 0, 0, 3'b000, 16'hffff);
    send_item(hi, 0, 0, 3'b001, 16'hffff);
    send_item(100, -200, 50, 3'b111, 16'hffff);
    send_item(hi, hi, hi, 3'b111, 16'h0000);
    send_item(lo, lo, lo, 3'b111, 16'hffff);
    send_item(4000, 4100, 4050, 3'b111, 16'h00f0);
    send_item(3000, 5000, 4000, 3'b111, 16'h1234);
    send_item(0, 3000, 3500, 3'b110, 16'hffff);
    send_item(0, -3000, -3500, 3'b110, 16'h8001);
    send_item(0, 1500, -1500, 3'b110, 16'haaaa);
    send_item(lo, hi, lo, 3'b011, 16'h5555);
    send_item(-8000, 9000, 100, 3'b101, 16'hffff);
    send_item(1023, 1023, -1023, 3'b111, 16'h0001);
    send_item(1024, 1024, 1024, 3'b111, 16'h8000);
    send_item(-2000, 20000, 20500, 3'b111, 16'h0f0f);
    drain();
  endtask

  task automatic test_random(int count);
    logic signed [15:0] base;
    logic [47:0] r;
    for (int i = 0; i < count; i++) begin
      r = 48'({$urandom, $urandom});
      case ($urandom_range(0, 3))
        0: send_item(r[15:0], r[31:16], r[47:32], 3'($urandom), 16'($urandom));
        1: begin
          base = 16'($urandom_range(0, 12000) - 2000);
          send_item(16'(base + $signed($urandom_range(0, 1500)) - 750),
                    16'(base + $signed($urandom_range(0, 1500)) - 750),
                    16'(base + $signed($urandom_range(0, 1500)) - 750),
                    3'($urandom), 16'($urandom));
        end
        2: begin
          base = 16'($urandom_range(0, 30000) - 15000);
          send_item(r[15:0], base, 16'(base + $signed($urandom_range(0, 3000)) - 1500),
                    {2'b11, r[16]}, 16'($urandom));
        end
        default: send_item(16'($signed($urandom_range(0, 2400)) - 1200),
                           16'($signed($urandom_range(0, 2400)) - 1200),
                           16'($signed($urandom_range(0, 2400)) - 1200),
                           3'($urandom), 16'($urandom));
      endcase
    end
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
      end
      test_random(120);
    join
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.curvature_thumb = '0;
    in_ch.curvature_index = '0;
    in_ch.curvature_middle = '0;
    in_ch.curvature_valid_mask = '0;
    in_ch.reading_valid_mask = '0;
    flat_thr = 15'd1024;
    uni_thr = 15'd2048;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    stall_mode = 1;
    test_random(150);
    write_reg(REG_FLAT, 32'hffff_0001);
    write_reg(REG_UNIFORM, 32'h0000_7fff);
    test_directed();
    stall_mode = 2;
    test_random(150);
    write_reg(REG_FLAT, 32'h7fff);
    write_reg(REG_UNIFORM, 32'h1);
    stall_mode = 0;
    test_random(130);
    write_reg(REG_FLAT, 32'h0);
    write_reg(REG_UNIFORM, 32'h8000);
    test_random(60);
    write_reg(REG_FLAT, 32'd3000);
    write_reg(REG_UNIFORM, 32'd600);
    stall_mode = 1;
    test_backpressure();
    test_random(150);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end
endmodule
